/* rtl/npq_pkg.sv */
// Shared types and constants for the nearest palette quantizer.
// Holds the beat payload structs, field widths and the palette reset colors.
// No dependencies.
package npq_pkg;

   // Field and datapath widths.
   localparam int CHAN_W      = 8;
   localparam int COLOUR_W    = 3 * CHAN_W;
   localparam int SQ_W        = 2 * CHAN_W;
   localparam int DIST_W      = SQ_W + 2;
   localparam int PAL_IDX_W   = 3;
   localparam int PAL_SLOTS   = 8;
   localparam int CSR_INDEX_W = 8;

   // Default palette depth.
   localparam int PALETTE_SIZE_DEFAULT = 5;

   // Alpha of every result pixel: fully opaque.
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // Distance given to unused tree slots; larger than any real distance.
   localparam logic [DIST_W-1:0] DIST_PAD = '1;

   // Input beat: one source pixel.
   typedef struct packed {
      logic [CHAN_W-1:0] in_red;
      logic [CHAN_W-1:0] in_green;
      logic [CHAN_W-1:0] in_blue;
   } req_pixel_type;

   // Output beat: snapped pixel and the chosen palette entry.
   typedef struct packed {
      logic [CHAN_W-1:0]    out_red;
      logic [CHAN_W-1:0]    out_green;
      logic [CHAN_W-1:0]    out_blue;
      logic [CHAN_W-1:0]    out_alpha;
      logic [PAL_IDX_W-1:0] chosen_index;
   } rsp_pixel_type;

   // Reset color of each palette slot, packed RGB with red on top.
   function automatic logic [COLOUR_W-1:0] pal_reset_colour(input logic [PAL_IDX_W-1:0] slot);
      logic [COLOUR_W-1:0] colour;
      case (slot)
         3'd1:    colour = 24'h8A908C;
         3'd2:    colour = 24'hFFFFFF;
         3'd3:    colour = 24'h00FF50;
         3'd4:    colour = 24'hFF1400;
         default: colour = 24'h000000;
      endcase
      return colour;
   endfunction

endpackage

/* rtl/nearest_palette_quantizer.sv */
// Throughput one pixel per cycle while rsp_stall is low.
// The stages are channel difference, square, distance sum, minimum tree and output register;
// each stage holds its beat only while the stage after it is full and stalled.
// Reset (synchronous, active high) empties the pipeline and loads the default palette.
// Palette registers are written through the csr port, which is always ready.
// Top level of the nearest palette quantizer; depends on npq_pkg.
module nearest_palette_quantizer #(
   parameter int PALETTE_SIZE = npq_pkg::PALETTE_SIZE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Pixel input channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  npq_pkg::req_pixel_type           req_data,
   // Result channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output npq_pkg::rsp_pixel_type           rsp_data,
   // Palette register write port.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [npq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [npq_pkg::COLOUR_W-1:0]     csr_data
);

   localparam int IDX_W  = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam int CW     = npq_pkg::CHAN_W;
   localparam int SW     = npq_pkg::SQ_W;
   localparam int DW     = npq_pkg::DIST_W;
   localparam int PIW    = npq_pkg::PAL_IDX_W;
   localparam int SLOTS  = npq_pkg::PAL_SLOTS;

   // Palette registers.
   logic [npq_pkg::COLOUR_W-1:0] palette_ff [PALETTE_SIZE];
   logic                         csr_hit;

   // Pipeline valids and per-stage ready.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

   // Stage payloads.
   logic [CW-1:0]    diff_in [PALETTE_SIZE][3];
   logic [CW-1:0]    diff_ff [PALETTE_SIZE][3];
   logic [SW-1:0]    sq_ff   [PALETTE_SIZE][3];
   logic [DW-1:0]    dist_in [PALETTE_SIZE];
   logic [DW-1:0]    dist_ff [PALETTE_SIZE];

   // Minimum tree.
   logic [DW-1:0]    leaf_dist [SLOTS];
   logic [PIW-1:0]   leaf_idx  [SLOTS];
   logic [DW-1:0]    l1_dist   [SLOTS/2];
   logic [PIW-1:0]   l1_idx    [SLOTS/2];
   logic [DW-1:0]    l2_dist   [SLOTS/4];
   logic [PIW-1:0]   l2_idx    [SLOTS/4];
   logic [DW-1:0]    best_dist_in;
   logic [PIW-1:0]   best_idx_in;
   logic [DW-1:0]    best_dist_ff;
   logic [PIW-1:0]   best_idx_ff;

   npq_pkg::rsp_pixel_type rsp_in;
   npq_pkg::rsp_pixel_type rsp_ff;
   logic [npq_pkg::COLOUR_W-1:0] chosen_colour;

   // Palette writes; indices at or beyond the palette depth are dropped.
   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && (csr_index < npq_pkg::CSR_INDEX_W'(PALETTE_SIZE));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PALETTE_SIZE; i++) begin
            palette_ff[i] <= npq_pkg::pal_reset_colour(PIW'(i));
         end
      end else if (csr_hit) begin
         palette_ff[csr_index[IDX_W-1:0]] <= csr_data;
      end
   end

   // A stage takes a new beat when it is empty or its content moves on.
   assign s5_ready  = !s5_valid_ff || !rsp_stall;
   assign s4_ready  = !s4_valid_ff || s5_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
         if (s5_ready) s5_valid_ff <= s4_valid_ff;
      end
   end

   // Stage 1: absolute channel differences against every palette entry.
   always_comb begin
      logic [CW-1:0] pix [3];
      logic [CW-1:0] pal [3];
      pix[0] = req_data.in_red;
      pix[1] = req_data.in_green;
      pix[2] = req_data.in_blue;
      for (int i = 0; i < PALETTE_SIZE; i++) begin
         pal[0] = palette_ff[i][3*CW-1:2*CW];
         pal[1] = palette_ff[i][2*CW-1:CW];
         pal[2] = palette_ff[i][CW-1:0];
         for (int c = 0; c < 3; c++) begin
            diff_in[i][c] = (pix[c] > pal[c]) ? (pix[c] - pal[c]) : (pal[c] - pix[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         diff_ff <= diff_in;
      end
   end

   // Stage 2: square each difference.
   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         for (int i = 0; i < PALETTE_SIZE; i++) begin
            for (int c = 0; c < 3; c++) begin
               sq_ff[i][c] <= SW'(diff_ff[i][c] * diff_ff[i][c]);
            end
         end
      end
   end

   // Stage 3: squared Euclidean distance per entry.
   always_comb begin
      for (int i = 0; i < PALETTE_SIZE; i++) begin
         dist_in[i] = DW'(sq_ff[i][0]) + DW'(sq_ff[i][1]) + DW'(sq_ff[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         dist_ff <= dist_in;
      end
   end

   // Stage 4: three-level minimum tree. Lower indices sit on the left and
   // win ties; unused slots carry a distance no real entry can reach.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         leaf_idx[i]  = PIW'(i);
         leaf_dist[i] = npq_pkg::DIST_PAD;
      end
      for (int i = 0; i < PALETTE_SIZE; i++) begin
         leaf_dist[i] = dist_ff[i];
      end
      for (int i = 0; i < SLOTS/2; i++) begin
         if (leaf_dist[2*i+1] < leaf_dist[2*i]) begin
            l1_dist[i] = leaf_dist[2*i+1];
            l1_idx[i]  = leaf_idx[2*i+1];
         end else begin
            l1_dist[i] = leaf_dist[2*i];
            l1_idx[i]  = leaf_idx[2*i];
         end
      end
      for (int i = 0; i < SLOTS/4; i++) begin
         if (l1_dist[2*i+1] < l1_dist[2*i]) begin
            l2_dist[i] = l1_dist[2*i+1];
            l2_idx[i]  = l1_idx[2*i+1];
         end else begin
            l2_dist[i] = l1_dist[2*i];
            l2_idx[i]  = l1_idx[2*i];
         end
      end
      if (l2_dist[1] < l2_dist[0]) begin
         best_dist_in = l2_dist[1];
         best_idx_in  = l2_idx[1];
      end else begin
         best_dist_in = l2_dist[0];
         best_idx_in  = l2_idx[0];
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         best_dist_ff <= best_dist_in;
         best_idx_ff  <= best_idx_in;
      end
   end

   // Stage 5: fetch the chosen color into the output register.
   assign chosen_colour = palette_ff[best_idx_ff[IDX_W-1:0]];

   always_comb begin
      rsp_in.out_red      = chosen_colour[3*CW-1:2*CW];
      rsp_in.out_green    = chosen_colour[2*CW-1:CW];
      rsp_in.out_blue     = chosen_colour[CW-1:0];
      rsp_in.out_alpha    = npq_pkg::ALPHA_OPAQUE;
      rsp_in.chosen_index = best_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (s5_ready && s4_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = s5_valid_ff;
   assign rsp_data  = rsp_ff;

   // The winning entry is always a real palette entry.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.chosen_index} < (PIW+1)'(PALETTE_SIZE)))
      else $error("chosen index beyond palette depth");

   // The winner is never farther than entry zero.
   assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (best_dist_ff <= $past(dist_ff[0]) || !$past(s4_ready)))
      else $error("tree result farther than entry zero");

   // A beat in the tree stage reaches the output when the output can take it.
   assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && s5_ready) |=> rsp_valid)
      else $error("beat lost between tree and output stage");

   // An accepted request always fills the first stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted request did not enter the pipeline");

endmodule

/* dv/nearest_palette_quantizer_tb.sv */
// Self-checking testbench for the nearest palette quantizer: a directed table of
// palette writes and pixels, then randomized phases with send gaps and result stalls.
// Depends on npq_pkg and nearest_palette_quantizer from the rtl folder.
module nearest_palette_quantizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import npq_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int PAL_COUNT     = PALETTE_SIZE_DEFAULT;
   localparam int PIPE_LATENCY  = 5;
   localparam int DRAIN_CYCLES  = PIPE_LATENCY + 3;
   localparam int CYCLE_LIMIT   = 400_000;
   localparam int MAX_REPORTS   = 40;
   localparam int NUM_PHASES    = 9;
   localparam int PHASE_PIXELS  = 120;
   localparam int HOLD_PHASE    = 2;
   localparam int QUIET_PHASE   = 5;
   localparam int DRAIN_PHASE   = 4;
   localparam int HOLD_CYCLES   = 80;
   localparam int MAX_BURST     = 11;

   // Palette register indexes, plus a few indexes the block must ignore.
   typedef enum logic [CSR_INDEX_W-1:0] {
      PAL_COLOUR_0,
      PAL_COLOUR_1,
      PAL_COLOUR_2,
      PAL_COLOUR_3,
      PAL_COLOUR_4
   } pal_reg_e;

   localparam logic [CSR_INDEX_W-1:0] FIRST_UNUSED_INDEX = CSR_INDEX_W'(PAL_COUNT);
   localparam logic [CSR_INDEX_W-1:0] LAST_SLOT_INDEX    = CSR_INDEX_W'(PAL_SLOTS - 1);
   localparam logic [CSR_INDEX_W-1:0] TOP_CSR_INDEX      = '1;

   // How each random phase fills the palette.
   typedef enum int {
      PAL_RANDOM,
      PAL_ZERO,
      PAL_FULL,
      PAL_CORNERS,
      PAL_DUPLICATES,
      PAL_CLUSTER,
      PAL_MIX_COUNT
   } palette_mix_e;

   // One row of the directed script: either a palette write or a pixel.
   typedef enum logic {ROW_WRITE, ROW_PIXEL} script_op_e;

   typedef struct packed {
      script_op_e                op;
      logic [CSR_INDEX_W-1:0]    index;
      logic [COLOUR_W-1:0]       value;
      req_pixel_type             pixel;
      logic                      fixed;
      rsp_pixel_type             want;
   } script_row_t;

   localparam rsp_pixel_type NO_WANT = '0;
   localparam int SCRIPT_LEN = 31;

   localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
      // Reset palette: exact hits, extremes and near misses.
      '{ROW_PIXEL, '0, '0, 24'h000000, 1'b1, '{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 3'd0}},
      '{ROW_PIXEL, '0, '0, 24'hFFFFFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, ALPHA_OPAQUE, 3'd2}},
      '{ROW_PIXEL, '0, '0, 24'h8A908C, 1'b1, '{8'h8A, 8'h90, 8'h8C, ALPHA_OPAQUE, 3'd1}},
      '{ROW_PIXEL, '0, '0, 24'h00FF50, 1'b1, '{8'h00, 8'hFF, 8'h50, ALPHA_OPAQUE, 3'd3}},
      '{ROW_PIXEL, '0, '0, 24'hFF1400, 1'b1, '{8'hFF, 8'h14, 8'h00, ALPHA_OPAQUE, 3'd4}},
      '{ROW_PIXEL, '0, '0, 24'hFF0000, 1'b1, '{8'hFF, 8'h14, 8'h00, ALPHA_OPAQUE, 3'd4}},
      '{ROW_PIXEL, '0, '0, 24'h00FF00, 1'b1, '{8'h00, 8'hFF, 8'h50, ALPHA_OPAQUE, 3'd3}},
      '{ROW_PIXEL, '0, '0, 24'hFF00FF, 1'b0, NO_WANT},
      '{ROW_PIXEL, '0, '0, 24'h0000FF, 1'b0, NO_WANT},
      '{ROW_PIXEL, '0, '0, 24'h7F7F7F, 1'b0, NO_WANT},
      // Writes past the palette must leave it untouched.
      '{ROW_WRITE, FIRST_UNUSED_INDEX, 24'hFFFFFF, '0, 1'b0, NO_WANT},
      '{ROW_WRITE, LAST_SLOT_INDEX, 24'h123456, '0, 1'b0, NO_WANT},
      '{ROW_WRITE, TOP_CSR_INDEX, 24'h000000, '0, 1'b0, NO_WANT},
      '{ROW_PIXEL, '0, '0, 24'h000000, 1'b1, '{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 3'd0}},
      '{ROW_PIXEL, '0, '0, 24'hFFFFFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, ALPHA_OPAQUE, 3'd2}},
      // Every entry equal: every pixel ties and entry zero wins.
      '{ROW_WRITE, PAL_COLOUR_0, 24'h404040, '0, 1'b0, NO_WANT},
      '{ROW_WRITE, PAL_COLOUR_1, 24'h404040, '0, 1'b0, NO_WANT},
      '{ROW_WRITE, PAL_COLOUR_2, 24'h404040, '0, 1'b0, NO_WANT},
      '{ROW_WRITE, PAL_COLOUR_3, 24'h404040, '0, 1'b0, NO_WANT},
      '{ROW_WRITE, PAL_COLOUR_4, 24'h404040, '0, 1'b0, NO_WANT},
      '{ROW_PIXEL, '0, '0, 24'h000000, 1'b1, '{8'h40, 8'h40, 8'h40, ALPHA_OPAQUE, 3'd0}},
      '{ROW_PIXEL, '0, '0, 24'hFFFFFF, 1'b1, '{8'h40, 8'h40, 8'h40, ALPHA_OPAQUE, 3'd0}},
      // Entries one and two sit at equal distance around a blue of 0x20.
      '{ROW_WRITE, PAL_COLOUR_0, 24'hFFFFFF, '0, 1'b0, NO_WANT},
      '{ROW_WRITE, PAL_COLOUR_1, 24'h000010, '0, 1'b0, NO_WANT},
      '{ROW_WRITE, PAL_COLOUR_2, 24'h000030, '0, 1'b0, NO_WANT},
      '{ROW_WRITE, PAL_COLOUR_3, 24'hFFFF00, '0, 1'b0, NO_WANT},
      '{ROW_WRITE, PAL_COLOUR_4, 24'hFF00FF, '0, 1'b0, NO_WANT},
      '{ROW_PIXEL, '0, '0, 24'h000020, 1'b0, NO_WANT},
      '{ROW_PIXEL, '0, '0, 24'h000000, 1'b0, NO_WANT},
      '{ROW_PIXEL, '0, '0, 24'hFFFF00, 1'b1, '{8'hFF, 8'hFF, 8'h00, ALPHA_OPAQUE, 3'd3}},
      '{ROW_PIXEL, '0, '0, 24'hFF00FF, 1'b1, '{8'hFF, 8'h00, 8'hFF, ALPHA_OPAQUE, 3'd4}}
   };

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_pixel_type          req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_pixel_type          rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [COLOUR_W-1:0]    csr_data  = '0;

   // Shadow of the palette registers and the snapped pixels still owed.
   logic [COLOUR_W-1:0] palette_shadow [PAL_COUNT] =
      '{24'h000000, 24'h8A908C, 24'hFFFFFF, 24'h00FF50, 24'hFF1400};
   rsp_pixel_type       owed_pixels [$];

   int error_count   = 0;
   int rsp_beats     = 0;
   int cycle_count   = 0;
   int send_gap_pct  = 0;
   int stall_pct     = 0;
   int hold_cycles   = 0;

   nearest_palette_quantizer #(
      .PALETTE_SIZE(PAL_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Squared RGB distance to every entry; the first entry wins ties.
   function automatic rsp_pixel_type nearest_colour(input req_pixel_type pix);
      int            dr;
      int            dg;
      int            db;
      int            dist_sq;
      int            best_dist;
      int            best;
      rsp_pixel_type snapped;
      best      = 0;
      best_dist = 0;
      for (int i = 0; i < PAL_COUNT; i++) begin
         dr      = int'(pix.in_red)   - int'(palette_shadow[i][23:16]);
         dg      = int'(pix.in_green) - int'(palette_shadow[i][15:8]);
         db      = int'(pix.in_blue)  - int'(palette_shadow[i][7:0]);
         dist_sq = dr * dr + dg * dg + db * db;
         if (i == 0 || dist_sq < best_dist) begin
            best_dist = dist_sq;
            best      = i;
         end
      end
      snapped.out_red      = palette_shadow[best][23:16];
      snapped.out_green    = palette_shadow[best][15:8];
      snapped.out_blue     = palette_shadow[best][7:0];
      snapped.out_alpha    = ALPHA_OPAQUE;
      snapped.chosen_index = PAL_IDX_W'(best);
      return snapped;
   endfunction

   task automatic report_mismatch(input string what, input logic [39:0] got,
                                  input logic [39:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("[%0t] rsp beat %0d: %s got 0x%0h, want 0x%0h",
                  $realtime, rsp_beats, what, got, want);
      end
   endtask

   // Palette write; the shadow follows only for indexes inside the palette.
   task automatic write_palette(input logic [CSR_INDEX_W-1:0] index,
                                input logic [COLOUR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index < PAL_COUNT) begin
         palette_shadow[index] = value;
      end
      @(posedge clock);
   endtask

   // Offer one pixel beat, record what it must snap to, then maybe go idle.
   task automatic send_pixel(input req_pixel_type pix, input rsp_pixel_type want);
      req_valid <= 1'b1;
      req_data  <= pix;
      do @(posedge clock); while (req_stall);
      owed_pixels.push_back(want);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, MAX_BURST)) @(posedge clock);
      end
   endtask

   // Stop sending and let the pipeline empty before touching the palette.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (owed_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: random stall bursts, or one long hold-off when asked.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, MAX_BURST)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check every accepted result beat against the oldest owed pixel.
   always @(posedge clock) begin
      rsp_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_pixels.size() == 0) begin
            report_mismatch("unexpected beat", 40'(rsp_data), '0);
         end else begin
            want = owed_pixels.pop_front();
            if (rsp_data.out_red !== want.out_red)
               report_mismatch("out_red", 40'(rsp_data.out_red), 40'(want.out_red));
            if (rsp_data.out_green !== want.out_green)
               report_mismatch("out_green", 40'(rsp_data.out_green), 40'(want.out_green));
            if (rsp_data.out_blue !== want.out_blue)
               report_mismatch("out_blue", 40'(rsp_data.out_blue), 40'(want.out_blue));
            if (rsp_data.out_alpha !== want.out_alpha)
               report_mismatch("out_alpha", 40'(rsp_data.out_alpha), 40'(want.out_alpha));
            if (rsp_data.chosen_index !== want.chosen_index)
               report_mismatch("chosen_index", 40'(rsp_data.chosen_index),
                               40'(want.chosen_index));
         end
         rsp_beats++;
      end
   end

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("nearest_palette_quantizer test failed");
      $finish;
   end

   initial begin
      script_row_t   row;
      req_pixel_type pixel;
      logic [23:0]   pix_bits;
      logic [23:0]   colour;
      logic [23:0]   base;
      palette_mix_e  mix_kind;
      bit            pixels_in_flight;
      int            mix;
      int            ia;
      int            ib;
      int            ca;
      int            cb;
      int            chan;

      pixels_in_flight = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed script, starting from the reset palette.
      for (int r = 0; r < SCRIPT_LEN; r++) begin
         row = SCRIPT[r];
         if (row.op == ROW_WRITE) begin
            if (pixels_in_flight) begin
               settle_pipeline();
               pixels_in_flight = 1'b0;
            end
            write_palette(row.index, row.value);
         end else begin
            send_pixel(row.pixel, row.fixed ? row.want : nearest_colour(row.pixel));
            pixels_in_flight = 1'b1;
         end
      end

      // Random phases, each with its own palette and idling pattern.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle_pipeline();
         mix_kind = palette_mix_e'(phase % PAL_MIX_COUNT);
         write_palette(CSR_INDEX_W'($urandom_range(PAL_COUNT, 255)), COLOUR_W'($urandom));
         base = COLOUR_W'($urandom);
         for (int i = 0; i < PAL_COUNT; i++) begin
            case (mix_kind)
               PAL_ZERO:    colour = '0;
               PAL_FULL:    colour = '1;
               PAL_CORNERS: colour = {$urandom_range(1) ? 8'hFF : 8'h00,
                                      $urandom_range(1) ? 8'hFF : 8'h00,
                                      $urandom_range(1) ? 8'hFF : 8'h00};
               PAL_DUPLICATES: begin
                  if (i > 0 && $urandom_range(1)) colour = palette_shadow[$urandom_range(i - 1)];
                  else colour = COLOUR_W'($urandom);
               end
               PAL_CLUSTER: colour = base ^ (COLOUR_W'($urandom) & 24'h070707);
               default:     colour = COLOUR_W'($urandom);
            endcase
            write_palette(CSR_INDEX_W'(i), colour);
         end

         // The hold-off phase streams without gaps so the block backs up.
         if (phase == HOLD_PHASE) begin
            send_gap_pct = 0;
            stall_pct    = 0;
            hold_cycles  = HOLD_CYCLES;
         end else if (phase == QUIET_PHASE || phase == NUM_PHASES - 1) begin
            send_gap_pct = 0;
            stall_pct    = 0;
         end else begin
            send_gap_pct = 15;
            stall_pct    = 25;
         end

         for (int n = 0; n < PHASE_PIXELS; n++) begin
            // Random pixels, near misses, midpoints and corners, in falling shares.
            mix = $urandom_range(99);
            ia  = $urandom_range(PAL_COUNT - 1);
            ib  = $urandom_range(PAL_COUNT - 1);
            for (int c = 0; c < 3; c++) begin
               ca = int'(palette_shadow[ia][c*8 +: 8]);
               cb = int'(palette_shadow[ib][c*8 +: 8]);
               if (mix < 45) chan = $urandom_range(255);
               else if (mix < 75) chan = ca + int'($urandom_range(16)) - 8;
               else if (mix < 90) chan = (ca + cb) / 2;
               else chan = $urandom_range(1) ? 255 : 0;
               if (chan < 0) chan = 0;
               else if (chan > 255) chan = 255;
               pix_bits[c*8 +: 8] = chan[7:0];
            end
            pixel = req_pixel_type'(pix_bits);
            send_pixel(pixel, nearest_colour(pixel));

            // In the drain phase the sender waits once, mid-phase, for every owed beat to come back.
            if (phase == DRAIN_PHASE && n == PHASE_PIXELS / 2) begin
               req_valid <= 1'b0;
               while (owed_pixels.size() != 0) @(posedge clock);
            end
         end
      end

      settle_pipeline();
      if (owed_pixels.size() != 0) begin
         report_mismatch("beats never returned", 40'(owed_pixels.size()), '0);
      end
      if (error_count == 0) begin
         $display("nearest_palette_quantizer test passed");
      end else begin
         $display("nearest_palette_quantizer test failed");
      end
      $finish;
   end

endmodule
